@@ hw/rtl/dfp_pkg.sv @@
// ----------------------------------------------------------------------------
// dfp_pkg
// Shared types, register indexes, policy modes and constants of the DVFS
// frequency policy.
// ----------------------------------------------------------------------------
package dfp_pkg;

  localparam int CounterWidthDefault = 64;
  localparam int SampleWidth         = 64;
  localparam int NumCounters         = 8;
  localparam int LimitWidth          = 32;
  localparam int FreqWidth           = 22;
  localparam int FreqValueWidth      = FreqWidth + 1;
  localparam int CfgIndexWidth       = 3;
  localparam int CfgDataWidth        = 32;

  // Counter slots within one sample.
  localparam int CntDram0   = 0;
  localparam int CntDram1   = 1;
  localparam int CntRxPkts  = 2;
  localparam int CntRxBytes = 3;
  localparam int CntTxPkts  = 4;
  localparam int CntTxBytes = 5;
  localparam int CntUser    = 6;
  localparam int CntIdle    = 7;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_MODE            = 3'd0,
    REG_ENERGY_LIMIT    = 3'd1,
    REG_COMBINED_LIMIT  = 3'd2,
    REG_BYTE_LIMIT      = 3'd3,
    REG_PACKET_LIMIT    = 3'd4,
    REG_LOW_FREQ        = 3'd5,
    REG_MID_FREQ        = 3'd6,
    REG_HIGH_FREQ       = 3'd7
  } reg_index_t;

  typedef enum logic [2:0] {
    MODE_NONE    = 3'd0,
    MODE_ENERGY  = 3'd1,
    MODE_BYTES   = 3'd2,
    MODE_PACKETS = 3'd3,
    MODE_ANY     = 3'd4,
    MODE_TREE    = 3'd5
  } mode_t;

  typedef struct packed {
    logic [2:0]            mode;
    logic [LimitWidth-1:0] energy_limit;
    logic [LimitWidth-1:0] combined_energy_limit;
    logic [LimitWidth-1:0] byte_limit;
    logic [LimitWidth-1:0] packet_limit;
    logic [FreqWidth-1:0]  low_freq;
    logic [FreqWidth-1:0]  mid_freq;
    logic [FreqWidth-1:0]  high_freq;
  } cfg_t;

  typedef struct packed {
    logic                 write;
    logic [FreqWidth-1:0] target;
  } decision_t;

  localparam logic [LimitWidth-1:0] EnergyLimitReset   = 32'd4000000;
  localparam logic [LimitWidth-1:0] CombinedLimitReset = 32'd3000000;
  localparam logic [LimitWidth-1:0] ByteLimitReset     = 32'd20000000;
  localparam logic [LimitWidth-1:0] PacketLimitReset   = 32'd10000;
  localparam logic [FreqWidth-1:0]  LowFreqReset       = 22'd1200000;
  localparam logic [FreqWidth-1:0]  MidFreqReset       = 22'd1300000;
  localparam logic [FreqWidth-1:0]  HighFreqReset      = 22'd2400000;

  // Decision tree split points; deltas are integers, so x <= 111.5 is x <= 111.
  localparam int TreeUserLimit = 111;
  localparam int TreeRxbLimit  = 95076;
  localparam int TreeIdleLimit = 79;
  localparam logic signed [FreqValueWidth-1:0] TreeFreqA = 23'sd1650000;
  localparam logic signed [FreqValueWidth-1:0] TreeFreqB = 23'sd1850000;
  localparam logic signed [FreqValueWidth-1:0] TreeFreqC = 23'sd2250000;

  localparam logic signed [FreqValueWidth-1:0] FreqUnknown = -23'sd1;

endpackage

@@ hw/rtl/dvfs_frequency_policy_top.sv @@
// ----------------------------------------------------------------------------
// dvfs_frequency_policy_top
// Frequency policy over samples of eight running counters: per-counter
// deltas, then a threshold or decision-tree choice of the next frequency.
// ----------------------------------------------------------------------------
//   Channel   Handshake            Payload
//   in        in_valid / in_stall  eight 64-bit counter samples
//   out       out_valid/ out_stall freq_write, freq_value
//   config    cfg_write            cfg_index, cfg_data
//
// Deltas are formed into the sample register as an item is accepted, and the
// decision is then made from them into the result register.
// One item per cycle is sustained; in_stall rises only while a result waits
// under out_stall and the sample register is full.
// Synchronous reset clears the previous sample to zero and the frequency to -1.
// ----------------------------------------------------------------------------
module dvfs_frequency_policy_top #(
  parameter int CW = dfp_pkg::CounterWidthDefault
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_write,
  input  logic [dfp_pkg::CfgIndexWidth-1:0]          cfg_index,
  input  logic [dfp_pkg::CfgDataWidth-1:0]           cfg_data,
  input  logic                                       in_valid,
  output logic                                       in_stall,
  input  logic [dfp_pkg::SampleWidth-1:0]            dram0_energy,
  input  logic [dfp_pkg::SampleWidth-1:0]            dram1_energy,
  input  logic [dfp_pkg::SampleWidth-1:0]            rx_packets,
  input  logic [dfp_pkg::SampleWidth-1:0]            rx_bytes,
  input  logic [dfp_pkg::SampleWidth-1:0]            tx_packets,
  input  logic [dfp_pkg::SampleWidth-1:0]            tx_bytes,
  input  logic [dfp_pkg::SampleWidth-1:0]            user_time,
  input  logic [dfp_pkg::SampleWidth-1:0]            idle_time,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output logic                                       freq_write,
  output logic signed [dfp_pkg::FreqValueWidth-1:0]  freq_value
);
  import dfp_pkg::*;

  cfg_t cfg;

  logic [NumCounters-1:0][CW-1:0] sample;
  logic [NumCounters-1:0][CW-1:0] prev;
  logic [NumCounters-1:0][CW-1:0] delta;
  logic                           s1_valid;
  logic signed [FreqValueWidth-1:0] cur_freq;
  logic signed [FreqValueWidth-1:0] cur_freq_next;
  decision_t                      dec;
  logic                           in_take;
  logic                           advance;

  assign sample[CntDram0]   = dram0_energy[CW-1:0];
  assign sample[CntDram1]   = dram1_energy[CW-1:0];
  assign sample[CntRxPkts]  = rx_packets[CW-1:0];
  assign sample[CntRxBytes] = rx_bytes[CW-1:0];
  assign sample[CntTxPkts]  = tx_packets[CW-1:0];
  assign sample[CntTxBytes] = tx_bytes[CW-1:0];
  assign sample[CntUser]    = user_time[CW-1:0];
  assign sample[CntIdle]    = idle_time[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode                  <= MODE_NONE;
      cfg.energy_limit          <= EnergyLimitReset;
      cfg.combined_energy_limit <= CombinedLimitReset;
      cfg.byte_limit            <= ByteLimitReset;
      cfg.packet_limit          <= PacketLimitReset;
      cfg.low_freq              <= LowFreqReset;
      cfg.mid_freq              <= MidFreqReset;
      cfg.high_freq             <= HighFreqReset;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE:           cfg.mode                  <= cfg_data[2:0];
        REG_ENERGY_LIMIT:   cfg.energy_limit          <= cfg_data;
        REG_COMBINED_LIMIT: cfg.combined_energy_limit <= cfg_data;
        REG_BYTE_LIMIT:     cfg.byte_limit            <= cfg_data;
        REG_PACKET_LIMIT:   cfg.packet_limit          <= cfg_data;
        REG_LOW_FREQ:       cfg.low_freq              <= cfg_data[FreqWidth-1:0];
        REG_MID_FREQ:       cfg.mid_freq              <= cfg_data[FreqWidth-1:0];
        REG_HIGH_FREQ:      cfg.high_freq             <= cfg_data[FreqWidth-1:0];
        default: ;
      endcase
    end
  end

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  // The previous sample moves on acceptance, so deltas are ready in order.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev     <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (in_take) begin
        prev     <= sample;
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      for (int i = 0; i < NumCounters; i++) begin
        delta[i] <= sample[i] - prev[i];
      end
    end
  end

  dfp_decide #(
    .CW (CW)
  ) u_decide (
    .cfg      (cfg),
    .delta    (delta),
    .cur_freq (cur_freq),
    .dec      (dec)
  );

  assign cur_freq_next = dec.write ? $signed({1'b0, dec.target}) : cur_freq;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_freq  <= FreqUnknown;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        cur_freq  <= cur_freq_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      freq_write <= dec.write;
      freq_value <= cur_freq_next;
    end
  end

endmodule

@@ hw/rtl/dfp_decide.sv @@
// ----------------------------------------------------------------------------
// dfp_decide
// Policy decision for one sample: threshold tests on summed deltas or the
// fixed decision tree, against the current frequency.
// ----------------------------------------------------------------------------
module dfp_decide #(
  parameter int CW = dfp_pkg::CounterWidthDefault
) (
  input  dfp_pkg::cfg_t                                    cfg,
  input  logic [dfp_pkg::NumCounters-1:0][CW-1:0]          delta,
  input  logic signed [dfp_pkg::FreqValueWidth-1:0]        cur_freq,
  output dfp_pkg::decision_t                               dec
);
  import dfp_pkg::*;

  localparam logic [CW-1:0] UserLim = CW'(TreeUserLimit);
  localparam logic [CW-1:0] RxbLim  = CW'(TreeRxbLimit);
  localparam logic [CW-1:0] IdleLim = CW'(TreeIdleLimit);

  logic [CW-1:0] energy_sum;
  logic [CW-1:0] byte_sum;
  logic [CW-1:0] packet_sum;
  logic          energy_over;
  logic          combined_over;
  logic          byte_over;
  logic          packet_over;
  logic          heavy;
  logic          user_low;
  logic          rxb_low;
  logic          idle_low;
  logic [FreqWidth-1:0] thr_target;
  logic          thr_write;

  // Sums wrap at the counter width and are then read as signed.
  assign energy_sum = delta[CntDram0] + delta[CntDram1];
  assign byte_sum   = delta[CntRxBytes] + delta[CntTxBytes];
  assign packet_sum = delta[CntRxPkts] + delta[CntTxPkts];

  assign energy_over   = $signed({energy_sum[CW-1], energy_sum}) >
                         $signed({{(CW+1-LimitWidth){1'b0}}, cfg.energy_limit});
  assign combined_over = $signed({energy_sum[CW-1], energy_sum}) >
                         $signed({{(CW+1-LimitWidth){1'b0}}, cfg.combined_energy_limit});
  assign byte_over     = $signed({byte_sum[CW-1], byte_sum}) >
                         $signed({{(CW+1-LimitWidth){1'b0}}, cfg.byte_limit});
  assign packet_over   = $signed({packet_sum[CW-1], packet_sum}) >
                         $signed({{(CW+1-LimitWidth){1'b0}}, cfg.packet_limit});

  assign user_low = $signed(delta[CntUser]) <= $signed(UserLim);
  assign rxb_low  = $signed(delta[CntRxBytes]) <= $signed(RxbLim);
  assign idle_low = $signed(delta[CntIdle]) <= $signed(IdleLim);

  always_comb begin
    case (cfg.mode)
      MODE_ENERGY:  heavy = energy_over;
      MODE_BYTES:   heavy = byte_over;
      MODE_PACKETS: heavy = packet_over;
      MODE_ANY:     heavy = byte_over | combined_over | packet_over;
      default:      heavy = 1'b0;
    endcase
  end

  assign thr_target = heavy ? cfg.low_freq : cfg.high_freq;
  assign thr_write  = $signed({1'b0, thr_target}) != cur_freq;

  always_comb begin
    dec.write  = 1'b0;
    dec.target = thr_target;
    case (cfg.mode)
      MODE_ENERGY, MODE_BYTES, MODE_PACKETS, MODE_ANY: begin
        dec.write = thr_write;
      end
      MODE_TREE: begin
        if (user_low) begin
          if (rxb_low) begin
            dec.write  = 1'b1;
            dec.target = cfg.mid_freq;
          end else begin
            dec.write  = cur_freq > TreeFreqA;
            dec.target = cfg.low_freq;
          end
        end else if (idle_low) begin
          dec.write  = cur_freq > TreeFreqB;
          dec.target = cfg.low_freq;
        end else begin
          dec.write  = cur_freq <= TreeFreqC;
          dec.target = cfg.high_freq;
        end
      end
      default: begin
        dec.write = 1'b0;
      end
    endcase
  end

endmodule

@@ hw/rtl/dfp_checker.sv @@
// ----------------------------------------------------------------------------
// dfp_checker
// Port-level checks of the DVFS frequency policy, bound to the top level.
// ----------------------------------------------------------------------------
module dfp_checker (
  input logic                                       clk,
  input logic                                       rst,
  input logic                                       in_stall,
  input logic                                       out_valid,
  input logic                                       out_stall,
  input logic                                       freq_write,
  input logic signed [dfp_pkg::FreqValueWidth-1:0]  freq_value
);
  import dfp_pkg::*;

  // No result can be shown in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // Input back-pressure only comes from a waiting, stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // A written frequency is a real frequency, never the unknown marker.
  a_write_known: assert property (@(posedge clk) disable iff (rst)
    (out_valid && freq_write) |-> !freq_value[FreqValueWidth-1])
    else $error("written frequency is negative");

  // Without a write, the frequency carries over from the previous item.
  a_hold_freq: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> (!out_valid || freq_write ||
                                   (freq_value == $past(freq_value))))
    else $error("frequency changed without a write");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(freq_write) &&
                                  $stable(freq_value)))
    else $error("stalled result changed");

endmodule

bind dvfs_frequency_policy_top dfp_checker u_dfp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .freq_write (freq_write),
  .freq_value (freq_value)
);
